[rtl/cmpre_pkg.sv]
// Shared types, codes and constants for the color mask palette run encoder.
package cmpre_pkg;

	// Input operation codes
	localparam logic [1:0] OP_LABEL = 2'd0;
	localparam logic [1:0] OP_LEARN = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FLIP_ROWS    = 2'd2;
	localparam logic [1:0] CFG_ADD_UNKNOWN  = 2'd3;

	// Configuration reset values
	localparam logic [12:0] DEF_FRAME_WIDTH  = 13'd640;
	localparam logic [12:0] DEF_FRAME_HEIGHT = 13'd480;
	localparam logic        DEF_FLIP_ROWS    = 1'b0;
	localparam logic        DEF_ADD_UNKNOWN  = 1'b1;

	// Parameter defaults
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_WIDTH_DEF     = 4096;

	// Row limit fixed by the field widths
	localparam int HEIGHT_LIM = 4096;

	// Palette index width at the largest palette
	localparam int LABEL_W = 12;

	// Small queues between the parts
	localparam int Q_DEPTH = 4;
	localparam int QAW     = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic        flip_rows;
		logic        add_unknown;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [23:0] color;
	} pix_t;

	// Outcome of a palette lookup, handed to the run encoder
	typedef struct packed {
		logic               clear;
		logic               known;
		logic [LABEL_W-1:0] label;
		logic               ovf;
	} cls_t;

	typedef struct packed {
		logic [7:0]  label;
		logic [11:0] row;
		logic [11:0] start_col;
		logic [12:0] end_col;
		logic        ovf;
		logic        last;
	} strip_t;

endpackage

[rtl/cmpre_front.sv]
// Front end: accepts pixel transactions, drops unused ops and queues the rest.
module cmpre_front import cmpre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pix_t        out_data
);

	pix_t           fifo_q [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	pix_t           pix;
	logic           push;
	logic           pop;

	always_comb begin
		pix.op    = in_data[1:0];
		pix.color = {in_data[9:2], in_data[17:10], in_data[25:18]};
	end

	assign in_ready  = cnt_q != (QAW+1)'(Q_DEPTH);
	// op 3 is consumed here and never reaches the back end
	assign push      = in_valid && in_ready && (pix.op != OP_NONE);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

endmodule

[rtl/cmpre_match.sv]
// Palette memory with a linear search engine; resolves each pixel to a label.
module cmpre_match import cmpre_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic add_unknown,
	input  logic in_valid,
	output logic in_ready,
	input  pix_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output cls_t out_data
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(PALETTE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [23:0]   palette_q [PALETTE_DEPTH];
	logic [1:0]    state_q;
	pix_t          pix_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [23:0]   rdata_s1;
	logic [AW-1:0] cmp_idx_s1;
	logic          cmp_vld_s1;
	logic          found_q;
	logic [AW-1:0] label_q;
	logic          out_vld_q;
	cls_t          out_q;

	logic hit;
	logic miss_end;
	logic room;
	logic is_learn;
	logic is_label;
	logic is_clear;
	logic add;
	logic done_go;
	logic wr_en;
	cls_t cls_next;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign hit      = cmp_vld_s1 && (rdata_s1 == pix_q.color);
	assign miss_end = cmp_vld_s1 && !hit && (CW'(cmp_idx_s1) == count_q - CW'(1));
	assign room     = count_q < CW'(PALETTE_DEPTH);
	assign is_learn = pix_q.op == OP_LEARN;
	assign is_label = pix_q.op == OP_LABEL;
	assign is_clear = pix_q.op == OP_CLEAR;
	assign add      = !found_q && room && (is_learn || (is_label && add_unknown));
	assign done_go  = (state_q == ST_DONE) && (is_learn || !out_vld_q || out_ready);
	assign wr_en    = done_go && add;

	always_comb begin
		cls_next.clear = is_clear;
		cls_next.known = found_q || add;
		cls_next.label = found_q ? LABEL_W'(label_q) : LABEL_W'(count_q);
		cls_next.ovf   = is_label && !found_q && add_unknown && !room;
	end

	// Palette storage: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette_q[count_q[AW-1:0]] <= pix_q.color;
		end
		rdata_s1   <= palette_q[rd_idx_q[AW-1:0]];
		cmp_idx_s1 <= rd_idx_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pix_q <= in_data;
		end
		if (state_q == ST_SEARCH && hit) begin
			label_q <= cmp_idx_s1;
		end
		if (done_go && !is_learn) begin
			out_q <= cls_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SEARCH) && (rd_idx_q < count_q);
			if (done_go && !is_learn) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						if (in_data.op == OP_CLEAR || count_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (rd_idx_q < count_q) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (miss_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						if (is_clear) begin
							count_q <= '0;
						end else if (add) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/cmpre_strip.sv]
// Run encoder: tracks raster position and open run, queues finished strips.
module cmpre_strip import cmpre_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  cls_t   in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output strip_t out_data
);

	localparam int WIDTH_LIM = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

	logic [11:0]        col_q;
	logic [11:0]        row_q;
	logic [LABEL_W-1:0] run_label_q;
	logic               run_known_q;
	logic [11:0]        run_start_q;
	strip_t             fifo_q [Q_DEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QAW:0]       cnt_q;

	logic [12:0]        w;
	logic [12:0]        h;
	logic [12:0]        wm1;
	logic [11:0]        colc;
	logic               last_col;
	logic [11:0]        row_out;
	logic               row_wrap;
	logic               rk0;
	logic               e1;
	logic               rk1;
	logic               take;
	logic [LABEL_W-1:0] nl;
	logic [11:0]        ns;
	logic               rk2;
	logic               e2;
	logic               step;
	logic               pop;
	logic [1:0]         n_push;
	strip_t             strip_a;
	strip_t             strip_b;

	always_comb begin
		if (cfg.frame_width == '0) begin
			w = 13'd1;
		end else if (cfg.frame_width > 13'(WIDTH_LIM)) begin
			w = 13'(WIDTH_LIM);
		end else begin
			w = cfg.frame_width;
		end
		if (cfg.frame_height == '0) begin
			h = 13'd1;
		end else if (cfg.frame_height > 13'(HEIGHT_LIM)) begin
			h = 13'(HEIGHT_LIM);
		end else begin
			h = cfg.frame_height;
		end
		wm1 = w - 13'd1;
		// clamp a position left past a reduced width onto the last column
		colc     = ({1'b0, col_q} > wm1) ? wm1[11:0] : col_q;
		last_col = ({1'b0, colc} + 13'd1) >= w;
		row_wrap = ({1'b0, row_q} + 13'd1) >= h;
		if (!cfg.flip_rows) begin
			row_out = row_q;
		end else if ({1'b0, row_q} < h) begin
			row_out = 12'(h - 13'd1 - {1'b0, row_q});
		end else begin
			row_out = '0;
		end

		rk0  = run_known_q && (colc != '0);
		e1   = rk0 && (!in_data.known || in_data.label != run_label_q);
		rk1  = rk0 && !e1;
		take = in_data.known && !rk1;
		nl   = take ? in_data.label : run_label_q;
		ns   = take ? colc : run_start_q;
		rk2  = rk1 || take;
		e2   = last_col && rk2;

		strip_a.label     = run_label_q[7:0];
		strip_a.row       = row_out;
		strip_a.start_col = run_start_q;
		strip_a.end_col   = {1'b0, colc};
		strip_a.ovf       = in_data.ovf;
		strip_a.last      = !e2;

		strip_b.label     = nl[7:0];
		strip_b.row       = row_out;
		strip_b.start_col = ns;
		strip_b.end_col   = w;
		strip_b.ovf       = in_data.ovf;
		strip_b.last      = 1'b1;
	end

	// Take a lookup only while two strip slots are free
	assign in_ready  = cnt_q <= (QAW+1)'(Q_DEPTH - 2);
	assign step      = in_valid && in_ready;
	assign n_push    = (step && !in_data.clear) ? (2'(e1) + 2'(e2)) : 2'd0;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= e1 ? strip_a : strip_b;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + QAW'(1)] <= strip_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			run_label_q <= '0;
			run_known_q <= 1'b0;
			run_start_q <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			cnt_q <= cnt_q + (QAW+1)'(n_push) - (QAW+1)'(pop);
			if (step) begin
				if (in_data.clear) begin
					col_q       <= '0;
					row_q       <= '0;
					run_label_q <= '0;
					run_known_q <= 1'b0;
					run_start_q <= '0;
				end else begin
					run_label_q <= nl;
					run_start_q <= ns;
					if (last_col) begin
						run_known_q <= 1'b0;
						col_q       <= '0;
						row_q       <= row_wrap ? 12'd0 : row_q + 12'd1;
					end else begin
						run_known_q <= rk2;
						col_q       <= colc + 12'd1;
					end
				end
			end
		end
	end

endmodule

[rtl/color_mask_palette_run_encoder_top.sv]
// Top level of the color mask palette run encoder: config registers and part wiring.
// Pixels enter on s_axis in raster order and are matched against a palette of distinct
// colors held in a memory with one registered read port; runs of one known label along
// a row leave on m_axis as strips (label, row, start column, end column exclusive), with
// tlast marking the last strip caused by one pixel. A pixel or learn op holds the palette
// search until it has a result: the palette is searched linearly, one entry per cycle
// through the memory's read port, so the rate falls as the palette fills; a clear op, or
// any op while the palette is empty, skips the search.
// A four-entry queue sits ahead of the search and a four-entry strip queue after the run
// encoder, so either stream may stall without stopping the other at once. No clearing
// pass follows reset. Write the configuration registers only while no pixel is in flight.
module color_mask_palette_run_encoder_top import cmpre_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[1:0], red[9:2], green[17:10], blue[25:18], zero fill
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// layer_label[7:0], strip_row[19:8], start_column[31:20], end_column[44:32],
	// palette_overflow[45], zero fill
	output logic [47:0] m_axis_tdata,
	// last_result
	output logic        m_axis_tlast
);

	cfg_t   cfg_q;
	logic   q_vld;
	logic   q_rdy;
	pix_t   q_pix;
	logic   cls_vld;
	logic   cls_rdy;
	cls_t   cls;
	strip_t strip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= DEF_FRAME_WIDTH;
			cfg_q.frame_height <= DEF_FRAME_HEIGHT;
			cfg_q.flip_rows    <= DEF_FLIP_ROWS;
			cfg_q.add_unknown  <= DEF_ADD_UNKNOWN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				CFG_FLIP_ROWS:    cfg_q.flip_rows    <= cfg_data[0];
				CFG_ADD_UNKNOWN:  cfg_q.add_unknown  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	cmpre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (q_vld),
		.out_ready (q_rdy),
		.out_data  (q_pix)
	);

	cmpre_match #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.add_unknown (cfg_q.add_unknown),
		.in_valid    (q_vld),
		.in_ready    (q_rdy),
		.in_data     (q_pix),
		.out_valid   (cls_vld),
		.out_ready   (cls_rdy),
		.out_data    (cls)
	);

	cmpre_strip #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_strip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (cls_vld),
		.in_ready  (cls_rdy),
		.in_data   (cls),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (strip)
	);

	assign m_axis_tdata = {2'b00, strip.ovf, strip.end_col, strip.start_col, strip.row,
		strip.label};
	assign m_axis_tlast = strip.last;

`ifndef ASSERT_OFF
	a_strip_end_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (strip.end_col != '0))
		else $error("strip with a zero end column");

	a_ovf_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		cls_vld && cls.ovf |-> !cls.known && !cls.clear)
		else $error("overflow flagged on a resolved or clear lookup");

	a_no_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		q_vld |-> (q_pix.op != OP_NONE))
		else $error("unused op reached the palette search");
`endif

endmodule
